// ===== design/pastel_border_fade_defines.svh =====
// ----------------------------------------------------------------------------
// Border fade assertion macros
// Concurrent check wrappers shared by the border fade RTL; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef PASTEL_BORDER_FADE_DEFINES_SVH
`define PASTEL_BORDER_FADE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PBF_ASSERT_IMP(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("pbf: same-cycle check failed");

// next-cycle implication
`define PBF_ASSERT_NXT(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("pbf: next-cycle check failed");

`else

`define PBF_ASSERT_IMP(label, ck, rn, ante, cons)
`define PBF_ASSERT_NXT(label, ck, rn, ante, cons)

`endif

`endif

// ===== design/pbf_pkg.sv =====
// ----------------------------------------------------------------------------
// Border fade package
// Widths, register codes, reset values and shared payload types.
// ----------------------------------------------------------------------------
package pbf_pkg;

	localparam int PIX_W = 8;
	localparam int POS_W = 12;
	localparam int DIM_W = 13;
	localparam int REM_W = 20;
	localparam int QUO_W = 8;
	localparam int IDX_W = 2;

	localparam logic [DIM_W-1:0] MAX_DIM    = 13'd4096;
	localparam logic [DIM_W-1:0] RST_BORDER = 13'd0;
	localparam logic [DIM_W-1:0] RST_WIDTH  = 13'd640;
	localparam logic [DIM_W-1:0] RST_HEIGHT = 13'd480;
	localparam logic [PIX_W-1:0] PIX_MAX    = 8'd255;

	typedef enum logic [IDX_W-1:0] {
		REG_BORDER_WIDTH = 2'd0,
		REG_IMAGE_WIDTH  = 2'd1,
		REG_IMAGE_HEIGHT = 2'd2
	} pbf_reg_t;

	typedef struct packed {
		logic [DIM_W-1:0] border_width;
		logic [DIM_W-1:0] image_width;
		logic [DIM_W-1:0] image_height;
	} pbf_cfg_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] row;
	} pbf_item_t;

	// one item in flight through the divider
	typedef struct packed {
		pbf_item_t        item;
		logic             active;
		logic [REM_W-1:0] rem;
		logic [QUO_W-1:0] quo;
	} pbf_dv_t;

endpackage

// ===== design/pbf_stream_if.sv =====
// ----------------------------------------------------------------------------
// Border fade stream interfaces
// Valid/ready channels for the pixel input and the faded pixel output.
// ----------------------------------------------------------------------------
interface pbf_pix_in_if;
	import pbf_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_in;
	logic [POS_W-1:0] col;
	logic [POS_W-1:0] row;

	modport source (output valid, output pixel_in, output col, output row, input ready);
	modport sink   (input valid, input pixel_in, input col, input row, output ready);
endinterface

interface pbf_pix_out_if;
	import pbf_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_out;

	modport source (output valid, output pixel_out, input ready);
	modport sink   (input valid, input pixel_out, output ready);
endinterface

// ===== design/pastel_border_fade.sv =====
// ----------------------------------------------------------------------------
// Pastel border fade
// Fades grey pixels toward white near the frame edges, one pixel per clock unless stalled.
// ----------------------------------------------------------------------------
// Takes one pixel beat per clock unless back-pressured and returns one
// faded pixel per beat, in order, through a register for the outer-frame
// rule, then the column pass and the row pass. Each pass computes its
// blend weight with an unrolled restoring divider by the border depth,
// one quotient bit per stage, and that chain is most of each pass's
// registers. Back-pressure collapses bubbles stage by stage. Write the
// registers only while no pixel is in flight.
module pastel_border_fade (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [pbf_pkg::IDX_W-1:0]   wr_index,
	input  logic [pbf_pkg::DIM_W-1:0]   wr_data,
	pbf_pix_in_if.sink                  pix_in,
	pbf_pix_out_if.source               pix_out
);
	import pbf_pkg::*;

	pbf_cfg_t  cfg;
	logic      frame;
	logic      rdy_s1;
	logic      valid_s1;
	pbf_item_t item_s1;
	logic      h_ready;
	logic      h_valid;
	pbf_item_t h_item;
	logic      v_ready;
	logic      v_valid;
	pbf_item_t v_item;

	pbf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_index(wr_index),
		.wr_data (wr_data),
		.cfg     (cfg)
	);

	// outermost frame goes to full white
	assign frame = (pix_in.col == '0) || (pix_in.row == '0)
		|| (({1'b0, pix_in.col} + 1'b1) == cfg.image_width)
		|| (({1'b0, pix_in.row} + 1'b1) == cfg.image_height);

	assign rdy_s1       = !valid_s1 || h_ready;
	assign pix_in.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rdy_s1) begin
			valid_s1 <= pix_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_in.valid && rdy_s1) begin
			item_s1.pixel <= frame ? PIX_MAX : pix_in.pixel_in;
			item_s1.col   <= pix_in.col;
			item_s1.row   <= pix_in.row;
		end
	end

	pbf_pass u_pass_h (
		.clk      (clk),
		.arst_n   (arst_n),
		.vert     (1'b0),
		.bw       (cfg.border_width),
		.size     (cfg.image_width),
		.in_valid (valid_s1),
		.in_ready (h_ready),
		.in_item  (item_s1),
		.out_valid(h_valid),
		.out_ready(v_ready),
		.out_item (h_item)
	);

	pbf_pass u_pass_v (
		.clk      (clk),
		.arst_n   (arst_n),
		.vert     (1'b1),
		.bw       (cfg.border_width),
		.size     (cfg.image_height),
		.in_valid (h_valid),
		.in_ready (v_ready),
		.in_item  (h_item),
		.out_valid(v_valid),
		.out_ready(pix_out.ready),
		.out_item (v_item)
	);

	assign pix_out.valid     = v_valid;
	assign pix_out.pixel_out = v_item.pixel;

endmodule

// ===== design/pbf_cfg.sv =====
// ----------------------------------------------------------------------------
// Border fade configuration registers
// Border depth and image size, saturated to the largest frame dimension.
// ----------------------------------------------------------------------------
`include "pastel_border_fade_defines.svh"

module pbf_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [pbf_pkg::IDX_W-1:0]   wr_index,
	input  logic [pbf_pkg::DIM_W-1:0]   wr_data,
	output pbf_pkg::pbf_cfg_t           cfg
);
	import pbf_pkg::*;

	logic [DIM_W-1:0] wr_sat;
	pbf_cfg_t         cfg_q;

	// clamp oversize writes to the largest frame
	assign wr_sat = (wr_data > MAX_DIM) ? MAX_DIM : wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.border_width <= RST_BORDER;
			cfg_q.image_width  <= RST_WIDTH;
			cfg_q.image_height <= RST_HEIGHT;
		end else if (wr_en) begin
			case (wr_index)
				REG_BORDER_WIDTH: cfg_q.border_width <= wr_sat;
				REG_IMAGE_WIDTH:  cfg_q.image_width  <= wr_sat;
				REG_IMAGE_HEIGHT: cfg_q.image_height <= wr_sat;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

	`PBF_ASSERT_IMP(a_border_max, clk, arst_n, 1'b1, cfg_q.border_width <= MAX_DIM)
	`PBF_ASSERT_IMP(a_size_max, clk, arst_n, 1'b1, (cfg_q.image_width <= MAX_DIM) && (cfg_q.image_height <= MAX_DIM))
	`PBF_ASSERT_NXT(a_border_wr, clk, arst_n, wr_en && (wr_index == REG_BORDER_WIDTH) && (wr_data <= MAX_DIM), cfg_q.border_width == $past(wr_data))

endmodule

// ===== design/pbf_div_step.sv =====
// ----------------------------------------------------------------------------
// Border fade divider step
// One restoring division step per stage: settle one quotient bit, then hold.
// ----------------------------------------------------------------------------
module pbf_div_step (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [2:0]                  bit_idx,
	input  logic [pbf_pkg::DIM_W-1:0]   bw,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  pbf_pkg::pbf_dv_t            in_dv,
	output logic                        out_valid,
	input  logic                        out_ready,
	output pbf_pkg::pbf_dv_t            out_dv
);
	import pbf_pkg::*;

	logic [REM_W-1:0] trial;
	pbf_dv_t          nxt;
	logic             valid_s1;
	pbf_dv_t          dv_s1;

	assign trial = {{(REM_W-DIM_W){1'b0}}, bw} << bit_idx;

	// skip idle beats: a zero border gives a zero trial that would set every bit
	always_comb begin
		nxt = in_dv;
		if (in_dv.active && (in_dv.rem >= trial)) begin
			nxt.rem          = in_dv.rem - trial;
			nxt.quo[bit_idx] = 1'b1;
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			dv_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_dv    = dv_s1;

endmodule

// ===== design/pbf_pass.sv =====
// ----------------------------------------------------------------------------
// Border fade pass
// One fade pass: edge distance, weight product, eight-step divide, blend.
// ----------------------------------------------------------------------------
`include "pastel_border_fade_defines.svh"

module pbf_pass (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        vert,
	input  logic [pbf_pkg::DIM_W-1:0]   bw,
	input  logic [pbf_pkg::DIM_W-1:0]   size,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  pbf_pkg::pbf_item_t          in_item,
	output logic                        out_valid,
	input  logic                        out_ready,
	output pbf_pkg::pbf_item_t          out_item
);
	import pbf_pkg::*;

	// edge distance
	logic [POS_W-1:0]       pos;
	logic                   lt;
	logic                   gt;
	logic [DIM_W:0]         reach;
	logic [DIM_W:0]         diff;
	logic [DIM_W:0]         dabs;
	logic [DIM_W-1:0]       edge_gap;
	logic                   act;

	logic                   rdy1;
	logic                   valid_s1;
	pbf_item_t              item_s1;
	logic                   active_s1;
	logic [DIM_W-1:0]       bd_s1;
	logic [PIX_W-1:0]       comp_s1;

	logic [DIM_W+PIX_W-1:0] prod;
	logic                   rdy2;
	logic                   valid_s2;
	pbf_dv_t                dv_s2;

	logic                   chain_valid [QUO_W+1];
	logic                   chain_ready [QUO_W+1];
	pbf_dv_t                chain_dv    [QUO_W+1];

	pbf_dv_t                last;
	logic [PIX_W:0]         sum;
	logic                   rdy11;
	logic                   valid_s11;
	pbf_item_t              item_s11;

	assign pos      = vert ? in_item.row : in_item.col;
	assign lt       = {1'b0, pos} < bw;
	assign reach    = {2'b00, pos} + {1'b0, bw};
	assign gt       = reach > {1'b0, size};
	assign diff     = {1'b0, size} - {2'b00, pos};
	assign dabs     = diff[DIM_W] ? (~diff + 1'b1) : diff;
	assign edge_gap = lt ? {1'b0, pos} : dabs[DIM_W-1:0];
	assign act      = (bw != '0) && (lt || gt) && (edge_gap < bw);

	assign rdy1     = !valid_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rdy1) begin
			valid_s1 <= in_valid;
		end
	end

	// an idle pass gets a zero weight, so its quotient stays zero
	always_ff @(posedge clk) begin
		if (in_valid && rdy1) begin
			item_s1   <= in_item;
			active_s1 <= act;
			bd_s1     <= act ? (bw - edge_gap) : '0;
			comp_s1   <= PIX_MAX - in_item.pixel;
		end
	end

	assign prod = bd_s1 * comp_s1;
	assign rdy2 = !valid_s2 || chain_ready[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rdy2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && rdy2) begin
			dv_s2.item   <= item_s1;
			dv_s2.active <= active_s1;
			dv_s2.rem    <= prod[REM_W-1:0];
			dv_s2.quo    <= '0;
		end
	end

	assign chain_valid[0] = valid_s2;
	assign chain_dv[0]    = dv_s2;

	// quotient bits from the top down, one per stage
	for (genvar k = 0; k < QUO_W; k++) begin : g_div
		pbf_div_step u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.bit_idx  (3'(QUO_W - 1 - k)),
			.bw       (bw),
			.in_valid (chain_valid[k]),
			.in_ready (chain_ready[k]),
			.in_dv    (chain_dv[k]),
			.out_valid(chain_valid[k+1]),
			.out_ready(chain_ready[k+1]),
			.out_dv   (chain_dv[k+1])
		);
	end

	assign last  = chain_dv[QUO_W];
	assign sum   = {1'b0, last.item.pixel} + {1'b0, last.quo};
	assign rdy11 = !valid_s11 || out_ready;
	assign chain_ready[QUO_W] = rdy11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s11 <= 1'b0;
		end else if (rdy11) begin
			valid_s11 <= chain_valid[QUO_W];
		end
	end

	always_ff @(posedge clk) begin
		if (chain_valid[QUO_W] && rdy11) begin
			item_s11.col   <= last.item.col;
			item_s11.row   <= last.item.row;
			item_s11.pixel <= sum[PIX_W-1:0];
		end
	end

	assign out_valid = valid_s11;
	assign out_item  = item_s11;

	`PBF_ASSERT_IMP(a_no_overflow, clk, arst_n, chain_valid[QUO_W], !sum[PIX_W])
	`PBF_ASSERT_IMP(a_rem_below, clk, arst_n, chain_valid[QUO_W] && last.active, last.rem < {{(REM_W-DIM_W){1'b0}}, bw})
	`PBF_ASSERT_IMP(a_idle_zero, clk, arst_n, chain_valid[QUO_W] && !last.active, last.quo == '0)

endmodule
